FILE: rtl/fpba_pkg.sv
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared types, codes and default sizes for the fit-policy block allocator.
// ----------------------------------------------------------------------------
package fpba_pkg;

	// default sizing of the block table
	localparam int BLOCK_SLOTS_DEF = 32;
	localparam int SIZE_BITS_DEF   = 16;

	// fixed field widths
	localparam int CMD_W      = 2;
	localparam int LOAD_IDX_W = 5;
	localparam int FIELD_W    = 16;
	localparam int MODE_W     = 2;
	localparam int COUNT_W    = 6;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 6;

	// command codes
	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	// fit policy codes (any other code acts as first fit)
	localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE      = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 1'd1;

	// search probe status handed from cell to cell
	typedef struct packed {
		logic active;
		logic found;
	} fpba_flag_t;

	// table update strobes broadcast to every cell
	typedef struct packed {
		logic load_en;
		logic clear_en;
		logic mark_en;
	} fpba_ctl_t;

endpackage

FILE: rtl/fpba_cell.sv
// ----------------------------------------------------------------------------
// fpba_cell
// One block slot: holds its size and used mark, and updates the passing
// search probe with its own candidate before handing it to the next cell.
// ----------------------------------------------------------------------------
module fpba_cell #(
	parameter int INDEX     = 0,
	parameter int SLOT_W    = 5,
	parameter int SIZE_BITS = fpba_pkg::SIZE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fpba_pkg::fpba_ctl_t                 ctl,
	input  logic [fpba_pkg::MODE_W-1:0]         mode,
	input  logic [fpba_pkg::COUNT_W-1:0]        count,
	input  logic [fpba_pkg::LOAD_IDX_W-1:0]     load_index,
	input  logic [SIZE_BITS-1:0]                load_size,
	input  logic [SLOT_W-1:0]                   mark_index,
	input  fpba_pkg::fpba_flag_t                flag_in,
	input  logic [SIZE_BITS-1:0]                req_in,
	input  logic [SLOT_W-1:0]                   pick_in,
	input  logic [SIZE_BITS-1:0]                left_in,
	input  logic [SIZE_BITS-1:0]                size_in,
	output fpba_pkg::fpba_flag_t                flag_out,
	output logic [SIZE_BITS-1:0]                req_out,
	output logic [SLOT_W-1:0]                   pick_out,
	output logic [SIZE_BITS-1:0]                left_out,
	output logic [SIZE_BITS-1:0]                size_out
);

	localparam logic [fpba_pkg::COUNT_W:0] IDX_WIDE = (fpba_pkg::COUNT_W + 1)'(INDEX);
	localparam logic [SLOT_W-1:0]          IDX_SLOT = SLOT_W'(INDEX);

	logic                 used_q;
	logic [SIZE_BITS-1:0] size_q;
	fpba_pkg::fpba_flag_t flag_q;
	logic [SIZE_BITS-1:0] req_q;
	logic [SLOT_W-1:0]    pick_q;
	logic [SIZE_BITS-1:0] left_q;
	logic [SIZE_BITS-1:0] psize_q;

	logic                 in_range;
	logic                 load_hit;
	logic                 mark_hit;
	logic                 eligible;
	logic [SIZE_BITS-1:0] left;
	logic                 take;

	// candidate check against the passing probe
	always_comb begin
		in_range = IDX_WIDE < {1'b0, count};
		load_hit = ctl.load_en && ({{(fpba_pkg::COUNT_W + 1 - fpba_pkg::LOAD_IDX_W){1'b0}},
			load_index} == IDX_WIDE);
		mark_hit = ctl.mark_en && (mark_index == IDX_SLOT);
		eligible = in_range && !used_q && (size_q >= req_in);
		left     = size_q - req_in;
		take     = eligible && (!flag_in.found
			|| ((mode == fpba_pkg::MODE_BEST) && (left < left_in))
			|| ((mode == fpba_pkg::MODE_WORST) && (left > left_in)));
	end

	// used mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (load_hit || ctl.clear_en) begin
			used_q <= 1'b0;
		end else if (mark_hit) begin
			used_q <= 1'b1;
		end
	end

	// block size storage
	always_ff @(posedge clk) begin
		if (load_hit) begin
			size_q <= load_size;
		end
	end

	// probe status stage, found held once the probe has passed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= '0;
		end else begin
			flag_q.active <= flag_in.active;
			if (flag_in.active) begin
				flag_q.found <= flag_in.found || eligible;
			end
		end
	end

	// probe payload stage, held once the probe has passed
	always_ff @(posedge clk) begin
		if (flag_in.active) begin
			req_q   <= req_in;
			pick_q  <= take ? IDX_SLOT : pick_in;
			left_q  <= take ? left : left_in;
			psize_q <= take ? size_q : size_in;
		end
	end

	assign flag_out = flag_q;
	assign req_out  = req_q;
	assign pick_out = pick_q;
	assign left_out = left_q;
	assign size_out = psize_q;

endmodule

FILE: rtl/fpba_chain.sv
// ----------------------------------------------------------------------------
// fpba_chain
// Row of block cells; the search probe enters cell 0 and leaves the last
// cell one slot per cycle.
// ----------------------------------------------------------------------------
module fpba_chain #(
	parameter int BLOCK_SLOTS = fpba_pkg::BLOCK_SLOTS_DEF,
	parameter int SIZE_BITS   = fpba_pkg::SIZE_BITS_DEF,
	parameter int SLOT_W      = 5
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  fpba_pkg::fpba_ctl_t             ctl,
	input  logic [fpba_pkg::MODE_W-1:0]     mode,
	input  logic [fpba_pkg::COUNT_W-1:0]    count,
	input  logic [fpba_pkg::LOAD_IDX_W-1:0] load_index,
	input  logic [SIZE_BITS-1:0]            load_size,
	input  logic [SLOT_W-1:0]               mark_index,
	input  logic                            start,
	input  logic [SIZE_BITS-1:0]            req,
	output fpba_pkg::fpba_flag_t            flag_out,
	output logic [SLOT_W-1:0]               pick_out,
	output logic [SIZE_BITS-1:0]            left_out,
	output logic [SIZE_BITS-1:0]            size_out
);

	fpba_pkg::fpba_flag_t flag_w [BLOCK_SLOTS+1];
	logic [SIZE_BITS-1:0] req_w  [BLOCK_SLOTS+1];
	logic [SLOT_W-1:0]    pick_w [BLOCK_SLOTS+1];
	logic [SIZE_BITS-1:0] left_w [BLOCK_SLOTS+1];
	logic [SIZE_BITS-1:0] size_w [BLOCK_SLOTS+1];

	// fresh probe at the head of the row
	assign flag_w[0].active = start;
	assign flag_w[0].found  = 1'b0;
	assign req_w[0]         = req;
	assign pick_w[0]        = '0;
	assign left_w[0]        = '0;
	assign size_w[0]        = '0;

	for (genvar i = 0; i < BLOCK_SLOTS; i++) begin : g_cell
		fpba_cell #(
			.INDEX     (i),
			.SLOT_W    (SLOT_W),
			.SIZE_BITS (SIZE_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.mode       (mode),
			.count      (count),
			.load_index (load_index),
			.load_size  (load_size),
			.mark_index (mark_index),
			.flag_in    (flag_w[i]),
			.req_in     (req_w[i]),
			.pick_in    (pick_w[i]),
			.left_in    (left_w[i]),
			.size_in    (size_w[i]),
			.flag_out   (flag_w[i+1]),
			.req_out    (req_w[i+1]),
			.pick_out   (pick_w[i+1]),
			.left_out   (left_w[i+1]),
			.size_out   (size_w[i+1])
		);
	end

	// probe leaving the last cell
	assign flag_out = flag_w[BLOCK_SLOTS];
	assign pick_out = pick_w[BLOCK_SLOTS];
	assign left_out = left_w[BLOCK_SLOTS];
	assign size_out = size_w[BLOCK_SLOTS];

endmodule

FILE: rtl/fit_policy_block_allocator.sv
// ----------------------------------------------------------------------------
// fit_policy_block_allocator
// Block table allocator with first, best and worst fit placement.
// ----------------------------------------------------------------------------
// Load and clear beats give no result. An allocate beat sends a probe down
// a row of BLOCK_SLOTS cells, one slot per cycle. The result sits in an
// output register, and the next input beat is taken once the probe has
// delivered its pick to that register. Reading an unloaded slot inside the
// searched range gives an unspecified result.
module fit_policy_block_allocator #(
	parameter int BLOCK_SLOTS = fpba_pkg::BLOCK_SLOTS_DEF,
	parameter int SIZE_BITS   = fpba_pkg::SIZE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration writes
	input  logic                               cfg_we,
	input  logic [fpba_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fpba_pkg::CFG_DATA_W-1:0]    cfg_data,
	// input beats
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [fpba_pkg::CMD_W-1:0]         command,
	input  logic [fpba_pkg::LOAD_IDX_W-1:0]    load_index,
	input  logic [fpba_pkg::FIELD_W-1:0]       load_size,
	input  logic [fpba_pkg::FIELD_W-1:0]       request_size,
	// result beats
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               granted,
	output logic [fpba_pkg::LOAD_IDX_W-1:0]    granted_block,
	output logic [fpba_pkg::FIELD_W-1:0]       granted_block_size,
	output logic [fpba_pkg::FIELD_W-1:0]       leftover
);

	localparam int SLOT_W = (BLOCK_SLOTS > 1) ? $clog2(BLOCK_SLOTS) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DONE
	} state_t;

	state_t                              state_q;
	logic [fpba_pkg::MODE_W-1:0]         mode_q;
	logic [fpba_pkg::COUNT_W-1:0]        count_q;
	logic                                out_valid_q;
	logic                                granted_q;
	logic [fpba_pkg::LOAD_IDX_W-1:0]     block_q;
	logic [fpba_pkg::FIELD_W-1:0]        bsize_q;
	logic [fpba_pkg::FIELD_W-1:0]        left_q;

	logic                                in_beat;
	logic                                commit;
	fpba_pkg::fpba_ctl_t                 ctl;
	fpba_pkg::fpba_flag_t                res_flag;
	logic [SLOT_W-1:0]                   res_pick;
	logic [SIZE_BITS-1:0]                res_left;
	logic [SIZE_BITS-1:0]                res_size;

	// handshake and table strobes
	always_comb begin
		in_ready     = (state_q == ST_IDLE);
		in_beat      = in_valid && in_ready;
		commit       = (state_q == ST_DONE) && (!out_valid_q || out_ready);
		ctl.load_en  = in_beat && (command == fpba_pkg::CMD_LOAD);
		ctl.clear_en = in_beat && (command == fpba_pkg::CMD_CLEAR);
		ctl.mark_en  = commit && res_flag.found;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= fpba_pkg::MODE_FIRST;
			count_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fpba_pkg::REG_FIT_MODE:      mode_q  <= cfg_data[fpba_pkg::MODE_W-1:0];
				fpba_pkg::REG_BLOCKS_IN_USE: count_q <= cfg_data[fpba_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	fpba_chain #(
		.BLOCK_SLOTS (BLOCK_SLOTS),
		.SIZE_BITS   (SIZE_BITS),
		.SLOT_W      (SLOT_W)
	) u_chain (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.mode       (mode_q),
		.count      (count_q),
		.load_index (load_index),
		.load_size  (SIZE_BITS'(load_size)),
		.mark_index (res_pick),
		.start      (in_beat && (command == fpba_pkg::CMD_ALLOC)),
		.req        (SIZE_BITS'(request_size)),
		.flag_out   (res_flag),
		.pick_out   (res_pick),
		.left_out   (res_left),
		.size_out   (res_size)
	);

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			granted_q   <= 1'b0;
			block_q     <= '0;
			bsize_q     <= '0;
			left_q      <= '0;
		end else begin
			if (out_valid_q && out_ready && !commit) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat && (command == fpba_pkg::CMD_ALLOC)) begin
						state_q <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					if (res_flag.active) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (commit) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
						granted_q   <= res_flag.found;
						block_q     <= res_flag.found ?
							fpba_pkg::LOAD_IDX_W'(res_pick) : '0;
						bsize_q     <= res_flag.found ?
							fpba_pkg::FIELD_W'(res_size) : '0;
						left_q      <= res_flag.found ?
							fpba_pkg::FIELD_W'(res_left) : '0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid          = out_valid_q;
	assign granted            = granted_q;
	assign granted_block      = block_q;
	assign granted_block_size = bsize_q;
	assign leftover           = left_q;

	// probe only leaves the row during a sweep
	a_probe_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		res_flag.active |-> (state_q == ST_SWEEP))
		else $error("probe left the cell row outside a sweep");

	// allocate beat starts a sweep
	a_alloc_sweeps: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && (command == fpba_pkg::CMD_ALLOC)) |=> (state_q == ST_SWEEP))
		else $error("allocate beat did not start a sweep");

	// a grant never leaves more than the block holds
	a_left_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && granted) |-> (leftover <= granted_block_size))
		else $error("leftover exceeds granted block size");

	// a refusal carries all-zero fields
	a_refuse_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !granted) |->
			((granted_block == '0) && (granted_block_size == '0) && (leftover == '0)))
		else $error("refused beat carries nonzero fields");

	// result register is written only when free or draining
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> (!out_valid_q || out_ready))
		else $error("result overwritten before it was taken");

endmodule

FILE: verif/fit_policy_grant_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_policy_grant_check
// Watches the command, grant and register ports of the block allocator. It
// keeps its own copy of the block table, used marks and policy registers,
// works out the grant for every allocate beat and compares each grant beat
// with the oldest one still due.
// ----------------------------------------------------------------------------
module fit_policy_grant_check #(
	parameter int BLOCK_SLOTS = fpba_pkg::BLOCK_SLOTS_DEF,
	parameter int SIZE_BITS   = fpba_pkg::SIZE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [fpba_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fpba_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic [fpba_pkg::CMD_W-1:0]         command,
	input  logic [fpba_pkg::LOAD_IDX_W-1:0]    load_index,
	input  logic [fpba_pkg::FIELD_W-1:0]       load_size,
	input  logic [fpba_pkg::FIELD_W-1:0]       request_size,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic                               granted,
	input  logic [fpba_pkg::LOAD_IDX_W-1:0]    granted_block,
	input  logic [fpba_pkg::FIELD_W-1:0]       granted_block_size,
	input  logic [fpba_pkg::FIELD_W-1:0]       leftover,
	output int                                 grants_pending,
	output int                                 fail_count
);
	import fpba_pkg::*;

	localparam int REPORT_LIMIT = 50;

	typedef struct packed {
		logic                  granted;
		logic [LOAD_IDX_W-1:0] block;
		logic [FIELD_W-1:0]    block_size;
		logic [FIELD_W-1:0]    leftover;
	} grant_t;

	// shadow of the allocator state
	logic [SIZE_BITS-1:0]   size_table [BLOCK_SLOTS];
	logic [BLOCK_SLOTS-1:0] taken;
	logic [MODE_W-1:0]      policy;
	logic [COUNT_W-1:0]     search_count;
	grant_t                 grants_due [$];
	grant_t                 oldest;

	task automatic report_mismatch(input string msg);
		if (fail_count < REPORT_LIMIT)
			$display("[%0t] grant mismatch: %s", $time, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("%s is %0d, %0d due", name, got, want));
	endtask

	// search the free slots and mark the one the policy picks
	function automatic grant_t place_request(input logic [SIZE_BITS-1:0] want);
		int                   span;
		int                   pick;
		bit                   hit;
		logic [SIZE_BITS-1:0] spare;
		logic [SIZE_BITS-1:0] pick_spare;
		grant_t               g;
		span = (search_count > BLOCK_SLOTS) ? BLOCK_SLOTS : int'(search_count);
		pick = 0;
		hit = 1'b0;
		pick_spare = '0;
		for (int j = 0; j < span; j++) begin
			if (!taken[j] && size_table[j] >= want) begin
				spare = size_table[j] - want;
				if (!hit) begin
					hit = 1'b1;
					pick = j;
					pick_spare = spare;
					if (policy != MODE_BEST && policy != MODE_WORST)
						break;
				end else if (policy == MODE_BEST && spare < pick_spare) begin
					pick = j;
					pick_spare = spare;
				end else if (policy == MODE_WORST && spare > pick_spare) begin
					pick = j;
					pick_spare = spare;
				end
			end
		end
		g = '0;
		if (hit) begin
			taken[pick] = 1'b1;
			g.granted = 1'b1;
			g.block = pick[LOAD_IDX_W-1:0];
			g.block_size = FIELD_W'(size_table[pick]);
			g.leftover = FIELD_W'(pick_spare);
		end
		return g;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken = '0;
			policy = MODE_FIRST;
			search_count = '0;
			grants_due.delete();
			grants_pending = 0;
			fail_count = 0;
		end else begin
			// grant beat against the oldest grant due
			if (out_valid && out_ready) begin
				if (grants_due.size() == 0) begin
					report_mismatch("grant beat with no allocate waiting");
				end else begin
					oldest = grants_due.pop_front();
					check_field("granted", int'(granted), int'(oldest.granted));
					check_field("granted_block", int'(granted_block), int'(oldest.block));
					check_field("granted_block_size", int'(granted_block_size),
						int'(oldest.block_size));
					check_field("leftover", int'(leftover), int'(oldest.leftover));
				end
			end
			// register writes
			if (cfg_we) begin
				if (cfg_index == REG_FIT_MODE)
					policy = cfg_data[MODE_W-1:0];
				else if (cfg_index == REG_BLOCKS_IN_USE)
					search_count = cfg_data[COUNT_W-1:0];
			end
			// command beat
			if (in_valid && in_ready) begin
				case (command)
					CMD_LOAD: begin
						if (load_index < BLOCK_SLOTS) begin
							size_table[load_index] = SIZE_BITS'(load_size);
							taken[load_index] = 1'b0;
						end
					end
					CMD_ALLOC: begin
						grants_due.push_back(place_request(SIZE_BITS'(request_size)));
					end
					CMD_CLEAR: begin
						taken = '0;
					end
					default: begin
					end
				endcase
			end
			grants_pending = grants_due.size();
		end
	end

endmodule

FILE: verif/fit_policy_block_allocator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_test
// Drives load, allocate and clear beats into the block allocator under every
// fit policy and a range of searched slot counts, with random gaps on the
// command side and random stalls on the grant side. A grant checker beside
// the block predicts and compares every grant beat.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_test;
	import fpba_pkg::*;

	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int DRAIN_CYCLES = BLOCK_SLOTS_DEF + 8;
	localparam int PHASES       = 12;
	localparam int PHASE_BEATS  = 150;

	// codes the package leaves unnamed
	localparam logic [CMD_W-1:0]  CMD_SPARE  = 2'd3;
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [CMD_W-1:0]      command;
	logic [LOAD_IDX_W-1:0] load_index;
	logic [FIELD_W-1:0]    load_size;
	logic [FIELD_W-1:0]    request_size;
	logic                  out_valid;
	logic                  out_ready;
	logic                  granted;
	logic [LOAD_IDX_W-1:0] granted_block;
	logic [FIELD_W-1:0]    granted_block_size;
	logic [FIELD_W-1:0]    leftover;

	int grants_pending;
	int fail_count;
	int cycle_count;
	bit quiet;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	fit_policy_block_allocator dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.command            (command),
		.load_index         (load_index),
		.load_size          (load_size),
		.request_size       (request_size),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.granted            (granted),
		.granted_block      (granted_block),
		.granted_block_size (granted_block_size),
		.leftover           (leftover)
	);

	fit_policy_grant_check grant_check (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.command            (command),
		.load_index         (load_index),
		.load_size          (load_size),
		.request_size       (request_size),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.granted            (granted),
		.granted_block      (granted_block),
		.granted_block_size (granted_block_size),
		.leftover           (leftover),
		.grants_pending     (grants_pending),
		.fail_count         (fail_count)
	);

	// run limit
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("fit_policy_block_allocator_test NOT OK");
			$finish;
		end
	end

	// grant side stalls: short runs mostly, now and then a long one
	initial begin
		int r;
		int hold;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			hold = 1;
			if (quiet) begin
				out_ready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					out_ready <= 1'b1;
					hold = $urandom_range(1, 12);
				end else if (r < 90) begin
					out_ready <= 1'b0;
					hold = $urandom_range(1, 3);
				end else begin
					out_ready <= 1'b0;
					hold = $urandom_range(8, 50);
				end
			end
			repeat (hold - 1) @(negedge clk);
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// sizes cluster low so that fits, misses and ties all turn up
	function automatic logic [FIELD_W-1:0] pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			case ($urandom_range(0, 6))
				0: return 16'd0;
				1: return 16'd1;
				2: return 16'd255;
				3: return 16'd256;
				4: return 16'd4096;
				5: return 16'd65534;
				default: return 16'd65535;
			endcase
		end
		if (r < 65)
			return FIELD_W'($urandom_range(0, 600));
		return FIELD_W'($urandom_range(0, 65535));
	endfunction

	// one command beat; returns at the falling edge after acceptance, valid still high
	task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [LOAD_IDX_W-1:0] idx,
			input logic [FIELD_W-1:0] lsize, input logic [FIELD_W-1:0] req);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		load_index <= idx;
		load_size <= lsize;
		request_size <= req;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// wait until every grant is back and the search has settled
	task automatic drain();
		in_valid <= 1'b0;
		while (grants_pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_policy(input logic [MODE_W-1:0] mode, input logic [COUNT_W-1:0] count);
		logic [31:0] noise;
		noise = $urandom;
		drain();
		cfg_we <= 1'b1;
		cfg_index <= REG_FIT_MODE;
		cfg_data <= {noise[CFG_DATA_W-MODE_W-1:0], mode};
		@(negedge clk);
		cfg_index <= REG_BLOCKS_IN_USE;
		cfg_data <= count;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic random_beat();
		int               r;
		logic [CMD_W-1:0] cmd;
		r = $urandom_range(0, 99);
		if (r < 55)
			cmd = CMD_ALLOC;
		else if (r < 82)
			cmd = CMD_LOAD;
		else if (r < 95)
			cmd = CMD_CLEAR;
		else
			cmd = CMD_SPARE;
		send_beat(cmd, LOAD_IDX_W'($urandom_range(0, 31)), pick_size(), pick_size());
	endtask

	initial begin
		logic [MODE_W-1:0]  mode;
		logic [COUNT_W-1:0] count;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_FIT_MODE;
		cfg_data = '0;
		in_valid = 1'b0;
		command = CMD_LOAD;
		load_index = '0;
		load_size = '0;
		request_size = '0;
		quiet = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// nothing searched after reset: no grant
		send_beat(CMD_ALLOC, 0, 0, 16'd0);

		// small table with ties and extreme sizes
		set_policy(MODE_FIRST, 6);
		send_beat(CMD_LOAD, 0, 16'd100, 0);
		send_beat(CMD_LOAD, 1, 16'd0, 0);
		send_beat(CMD_LOAD, 2, 16'd65535, 0);
		send_beat(CMD_LOAD, 3, 16'd300, 0);
		send_beat(CMD_LOAD, 4, 16'd100, 0);
		send_beat(CMD_LOAD, 5, 16'd300, 0);
		send_beat(CMD_LOAD, 31, 16'd65535, 0);
		send_beat(CMD_ALLOC, 0, 0, 16'd300);
		send_beat(CMD_ALLOC, 0, 0, 16'd0);
		// largest block already taken: no fit
		send_beat(CMD_ALLOC, 0, 0, 16'd65535);
		send_beat(CMD_CLEAR, 0, 0, 0);

		// best fit, equal leftovers go to the lower slot
		set_policy(MODE_BEST, 6);
		send_beat(CMD_ALLOC, 0, 0, 16'd100);
		send_beat(CMD_ALLOC, 0, 0, 16'd100);
		send_beat(CMD_ALLOC, 0, 0, 16'd0);
		send_beat(CMD_ALLOC, 0, 0, 16'd1);

		// worst fit, then reload frees a used slot
		set_policy(MODE_WORST, 6);
		send_beat(CMD_CLEAR, 0, 0, 0);
		send_beat(CMD_ALLOC, 0, 0, 16'd0);
		send_beat(CMD_ALLOC, 0, 0, 16'd100);
		send_beat(CMD_LOAD, 2, 16'd65535, 0);
		send_beat(CMD_ALLOC, 0, 0, 16'd65535);

		// unused policy code behaves as first fit; unused command is dropped
		set_policy(MODE_SPARE, 6);
		send_beat(CMD_ALLOC, 0, 0, 16'd0);
		send_beat(CMD_SPARE, 5'd31, 16'd65535, 16'd65535);
		send_beat(CMD_ALLOC, 0, 0, 16'd1);

		// random phases; the whole table is loaded before any wide search
		for (int p = 0; p < PHASES; p++) begin
			if (p == 0) begin
				for (int j = 0; j < BLOCK_SLOTS_DEF; j++)
					send_beat(CMD_LOAD, LOAD_IDX_W'(j), pick_size(),
						FIELD_W'($urandom_range(0, 65535)));
			end
			case (p % 4)
				0: mode = MODE_FIRST;
				1: mode = MODE_BEST;
				2: mode = MODE_WORST;
				default: mode = MODE_SPARE;
			endcase
			case (p)
				0: count = 32;
				1: count = 63;
				2: count = 1;
				3: count = 0;
				4: count = 33;
				default: count = COUNT_W'($urandom_range(1, 63));
			endcase
			quiet = (p % 5 == 2);
			set_policy(mode, count);
			repeat (PHASE_BEATS) random_beat();
		end

		quiet = 1'b0;
		drain();
		if (fail_count == 0)
			$display("fit_policy_block_allocator_test OK");
		else
			$display("fit_policy_block_allocator_test NOT OK");
		$finish;
	end

endmodule
